[rtl/core/bfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the body frame attitude block
// Request and result structs, sequencer states, fixed-point constants and the
// arctangent table used by the CORDIC unit.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // default build values
  localparam int VEC_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS_DEF  = 16;

  // q30 angle and gain constants, signed: angles 36 bits, gain 34 bits
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

  // configuration register indexes
  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_START_Z = 2'd2;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_YAW   = 2'd1,
    OP_ROLL  = 2'd2,
    OP_PITCH = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE_MUL,
    ST_MOVE_ADD,
    ST_CORDIC,
    ST_ROT_VC,
    ST_ROT_US,
    ST_ROT_W,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CR_AB,
    ST_CR_CD,
    ST_CR_OUT,
    ST_FINISH
  } state_e;

  typedef logic [2:0][15:0] vec_t;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] fwd_i;
    logic signed [15:0] fwd_j;
    logic signed [15:0] fwd_k;
    logic signed [15:0] up_i;
    logic signed [15:0] up_j;
    logic signed [15:0] up_k;
    logic signed [15:0] side_i;
    logic signed [15:0] side_j;
    logic signed [15:0] side_k;
  } out_rsp_t;

  // arctangent of 2^-i in q30
  function automatic logic [31:0] atan_step(input logic [4:0] i);
    logic [31:0] res;
    case (i)
      5'd0:    res = 32'd843314857;
      5'd1:    res = 32'd497837829;
      5'd2:    res = 32'd263043837;
      5'd3:    res = 32'd133525159;
      5'd4:    res = 32'd67021687;
      5'd5:    res = 32'd33543516;
      5'd6:    res = 32'd16775851;
      5'd7:    res = 32'd8388437;
      5'd8:    res = 32'd4194283;
      5'd9:    res = 32'd2097149;
      5'd10:   res = 32'd1048576;
      5'd31:   res = 32'd0;
      default: res = 32'd1 << (5'd30 - i);
    endcase
    return res;
  endfunction

  // clamp to the 16-bit signed range
  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] res;
    if (v > 64'sd32767) res = 16'h7fff;
    else if (v < -64'sd32768) res = 16'h8000;
    else res = v[15:0];
    return res;
  endfunction

endpackage

[rtl/core/body_frame_attitude_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_frame_attitude_update: vehicle position and body frame keeper
// Move, yaw, roll and pitch requests update the position and the frame; each
// request returns the full state.
// ----------------------------------------------------------------------------
// One request at a time. A move runs each axis in turn through the one shared
// 32x32 multiplier. A yaw, roll or pitch runs the CORDIC loop, the 32-step
// square root and up to three restoring divides of VEC_FRAC_BITS + 33 bits,
// and the multiplier is shared by the rotate, square and cross product steps.
// A finished result sits in an output register, so the next request is taken
// while it waits, unless a second result is ready first. Writes to the start
// registers load the position at once; the block has no clearing pass.
// ----------------------------------------------------------------------------
module body_frame_attitude_update import bfa_pkg::*; #(
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_rsp_t    out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int NUM_W   = VEC_FRAC_BITS + 33;
  localparam int MOVE_SH = VEC_FRAC_BITS - 8;
  localparam int ONE_INT = (VEC_FRAC_BITS >= 15) ? 32767 : (1 << VEC_FRAC_BITS);
  localparam logic [15:0] ONE     = 16'(ONE_INT);
  localparam logic [15:0] NEG_ONE = 16'(-ONE_INT);
  localparam logic signed [63:0] MOVE_RND = 64'sd1 <<< (MOVE_SH - 1);
  localparam logic signed [63:0] ROT_RND  = 64'sd1 <<< 15;
  localparam logic signed [63:0] CR_RND   = 64'sd1 <<< (VEC_FRAC_BITS - 1);

  state_e             state_q, state_d;
  logic [1:0]         k_q, k_d, k1, k2;
  op_e                op_q;
  logic signed [15:0] speed_q;
  logic [2:0][31:0]   pos_q, w_q;
  vec_t               fwd_q, up_q, side_q;
  vec_t               v_sel, u_sel, a_sel, b_sel;
  logic signed [63:0] acc_q, prod, mv_d, rot_w, cr_v;
  logic signed [31:0] mul_a, mul_b;
  logic [63:0]        m2_q;
  logic               wneg_q, out_valid_q;
  out_rsp_t           out_q;

  logic               accept, k_last, k_step, load;
  logic               cor_start, cor_done, sq_start, sq_done, dv_start, dv_done;
  logic signed [31:0] cos_v, sin_v, w_sel;
  logic [31:0]        root, w_abs;
  logic [NUM_W-1:0]   num, quo;
  logic signed [33:0] pos_sum;
  logic [31:0]        pos_new;
  logic [15:0]        div_res;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign k_last     = (k_q == 2'd2);

  // operand routing by operation
  assign v_sel = (op_q == OP_PITCH) ? fwd_q : side_q;
  assign u_sel = (op_q == OP_YAW) ? fwd_q : up_q;
  assign a_sel = (op_q == OP_YAW) ? up_q : side_q;
  assign b_sel = (op_q == OP_YAW) ? side_q : fwd_q;

  // cyclic neighbours for the cross product
  always_comb begin
    case (k_q)
      2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
      2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
      default: begin k1 = 2'd0; k2 = 2'd1; end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MOVE_MUL: begin mul_a = 32'($signed(fwd_q[k_q])); mul_b = 32'(speed_q); end
      ST_ROT_VC:   begin mul_a = 32'($signed(v_sel[k_q])); mul_b = cos_v; end
      ST_ROT_US:   begin mul_a = 32'($signed(u_sel[k_q])); mul_b = sin_v; end
      ST_SQ_MUL:   begin mul_a = w_sel; mul_b = w_sel; end
      ST_CR_AB:    begin mul_a = 32'($signed(a_sel[k1])); mul_b = 32'($signed(b_sel[k2])); end
      ST_CR_CD:    begin mul_a = 32'($signed(a_sel[k2])); mul_b = 32'($signed(b_sel[k1])); end
      default:     begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign w_sel = $signed(w_q[k_q]);

  // rounding and saturation helpers
  assign mv_d    = (acc_q + MOVE_RND) >>> MOVE_SH;
  assign pos_sum = 34'($signed(pos_q[k_q])) + 34'(mv_d);
  assign pos_new = (pos_sum > 34'sd2147483647) ? 32'h7fffffff :
                   (pos_sum < -34'sd2147483648) ? 32'h80000000 : pos_sum[31:0];
  assign rot_w   = (acc_q + ROT_RND) >>> 16;
  assign cr_v    = (acc_q + CR_RND) >>> VEC_FRAC_BITS;
  assign w_abs   = w_sel[31] ? 32'(-w_sel) : w_sel;
  assign num     = (NUM_W'(w_abs) << VEC_FRAC_BITS) + NUM_W'(root >> 1);
  assign div_res = wneg_q ? ((quo > NUM_W'(32768)) ? 16'h8000 : 16'(17'd0 - quo[16:0]))
                          : ((quo > NUM_W'(32767)) ? 16'h7fff : quo[15:0]);

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_step    = 1'b0;
    cor_start = 1'b0;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.op == OP_MOVE) begin
            state_d = ST_MOVE_MUL;
          end else begin
            state_d   = ST_CORDIC;
            cor_start = 1'b1;
          end
        end
      end
      ST_MOVE_MUL: state_d = ST_MOVE_ADD;
      ST_MOVE_ADD: begin
        k_step  = 1'b1;
        state_d = k_last ? ST_FINISH : ST_MOVE_MUL;
      end
      ST_CORDIC:   if (cor_done) state_d = ST_ROT_VC;
      ST_ROT_VC:   state_d = ST_ROT_US;
      ST_ROT_US:   state_d = ST_ROT_W;
      ST_ROT_W: begin
        k_step  = 1'b1;
        state_d = k_last ? ST_SQ_MUL : ST_ROT_VC;
      end
      ST_SQ_MUL:   state_d = ST_SQ_ACC;
      ST_SQ_ACC: begin
        k_step = 1'b1;
        if (k_last) begin
          state_d  = ST_SQRT;
          sq_start = 1'b1;
        end else begin
          state_d = ST_SQ_MUL;
        end
      end
      ST_SQRT:     if (sq_done) state_d = ST_DIV_GO;
      ST_DIV_GO: begin
        if (root == '0) begin
          k_step  = 1'b1;
          state_d = k_last ? ST_CR_AB : ST_DIV_GO;
        end else begin
          dv_start = 1'b1;
          state_d  = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (dv_done) begin
          k_step  = 1'b1;
          state_d = k_last ? ST_CR_AB : ST_DIV_GO;
        end
      end
      ST_CR_AB:    state_d = ST_CR_CD;
      ST_CR_CD:    state_d = ST_CR_OUT;
      ST_CR_OUT: begin
        k_step  = 1'b1;
        state_d = k_last ? ST_FINISH : ST_CR_AB;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    k_d = k_step ? (k_last ? 2'd0 : k_q + 2'd1) : k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= 2'd0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fwd_q  <= {NEG_ONE, 16'd0, 16'd0};
      up_q   <= {16'd0, ONE, 16'd0};
      side_q <= {16'd0, 16'd0, ONE};
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_START_X: pos_q[0] <= cfg_wdata_i;
          CFG_START_Y: pos_q[1] <= cfg_wdata_i;
          CFG_START_Z: pos_q[2] <= cfg_wdata_i;
          default:     ;
        endcase
      end else if (state_q == ST_MOVE_ADD) begin
        pos_q[k_q] <= pos_new;
      end
      // renormalized vector
      if ((state_q == ST_DIV_GO && root == '0) || (state_q == ST_DIV_WAIT && dv_done)) begin
        if (op_q == OP_PITCH) fwd_q[k_q] <= (root == '0) ? 16'd0 : div_res;
        else side_q[k_q] <= (root == '0) ? 16'd0 : div_res;
      end
      // rebuilt vector
      if (state_q == ST_CR_OUT) begin
        if (op_q == OP_YAW) fwd_q[k_q] <= sat16(cr_v);
        else up_q[k_q] <= sat16(cr_v);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_req_i.op;
      speed_q <= in_req_i.speed;
      m2_q    <= '0;
    end
    case (state_q)
      ST_MOVE_MUL, ST_ROT_VC, ST_SQ_MUL, ST_CR_AB: acc_q <= prod;
      ST_ROT_US:  acc_q <= acc_q + prod;
      ST_CR_CD:   acc_q <= acc_q - prod;
      ST_ROT_W:   w_q[k_q] <= rot_w[31:0];
      ST_SQ_ACC:  m2_q <= m2_q + acc_q;
      ST_DIV_GO:  wneg_q <= w_sel[31];
      default:    ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= {pos_q[0], pos_q[1], pos_q[2], fwd_q[0], fwd_q[1], fwd_q[2],
                up_q[0], up_q[1], up_q[2], side_q[0], side_q[1], side_q[2]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // shared iterative units
  bfa_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i (cor_start),
    .angle_i (in_req_i.angle),
    .done_o  (cor_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  bfa_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i (sq_start),
    .rad_i   (m2_q + acc_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  bfa_div #(.NUM_W(NUM_W)) u_div (
    .clk_i, .rst_ni,
    .start_i (dv_start),
    .num_i   (num),
    .den_i   (root),
    .done_o  (dv_done),
    .quo_o   (quo)
  );

endmodule

[rtl/core/bfa_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_cordic: iterative CORDIC sine and cosine
// One rotation step per cycle on q30 values; the angle is folded into the
// right half plane first and the results negated when folded.
// ----------------------------------------------------------------------------
module bfa_cordic import bfa_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int IW = $clog2(CORDIC_STEPS);

  logic signed [33:0] x_q, y_q;
  logic signed [35:0] z_q;
  logic [IW-1:0]      i_q;
  logic               busy_q, done_q, neg_q;
  logic signed [35:0] z0, atan;
  logic signed [33:0] x_sh, y_sh;

  // angle to q30
  assign z0   = {{3{angle_i[15]}}, angle_i, 17'd0};
  assign atan = $signed({4'd0, atan_step(5'(i_q))});
  assign x_sh = x_q >>> i_q;
  assign y_sh = y_q >>> i_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 1'b1;
      if (i_q == IW'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= Q30_GAIN;
      y_q <= '0;
      if (z0 > Q30_HALF_PI) begin
        z_q   <= z0 - Q30_PI;
        neg_q <= 1'b1;
      end else if (z0 < -Q30_HALF_PI) begin
        z_q   <= z0 + Q30_PI;
        neg_q <= 1'b1;
      end else begin
        z_q   <= z0;
        neg_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (!z_q[35]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? 32'(-x_q) : x_q[31:0];
  assign sin_o  = neg_q ? 32'(-y_q) : y_q[31:0];

endmodule

[rtl/core/bfa_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_sqrt: bit-serial integer square root
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module bfa_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] n_q, r_q, b_q, rb;
  logic        busy_q, done_q;

  assign rb = r_q + b_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && b_q[0]) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  // one result bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= rad_i;
      r_q <= '0;
      b_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (n_q >= rb) begin
        n_q <= n_q - rb;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

[rtl/core/bfa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_div: restoring unsigned divider
// One quotient bit per cycle, NUM_W quotient bits per divide.
// ----------------------------------------------------------------------------
module bfa_div #(
  parameter int NUM_W = 47
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [31:0]      den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [32:0]      rem_q, rem_sh;
  logic [31:0]      den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q, fits;

  assign rem_sh = {rem_q[31:0], quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/bfa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_checker: port-level checks of the body frame attitude block
// Watches the request and result handshakes of the top level.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // busy right after a request is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request");

  // ready only drops because a request came in
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("ready dropped without a request");

endmodule

bind body_frame_attitude_update bfa_checker u_bfa_checker (.*);

[tb/bfa_state_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_state_checker: scoreboard for the body frame attitude block
// Watches the request, result and register write ports, keeps its own copy of
// position and body frame, works out the state each request should return and
// compares every result field by field against the oldest expected state.
// ----------------------------------------------------------------------------
module bfa_state_checker import bfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_req_t     in_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_rsp_t    out_rsp_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam int FRAC  = VEC_FRAC_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI      = 64'sd3373259426;
  localparam longint GAIN    = 64'sd652032874;

  // arctangent of 2^-i in q30, first eleven steps
  localparam longint ATAN_Q30 [11] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

  int      pos [3];
  shortint fwd [3];
  shortint up  [3];
  shortint side[3];
  out_rsp_t expected_states[$];
  int       mismatches = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = expected_states.size();

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic shortint clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sd32768;
    return shortint'(v);
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint atan_of_step(int i);
    if (i < 11) return ATAN_Q30[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  // cosine and sine in q30, angle folded into +-pi/2 first
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, t;
    bit     flip;
    x = GAIN; y = 0; z = ang; flip = 0;
    if (z > HALF_PI) begin
      z -= PI; flip = 1;
    end else if (z < -HALF_PI) begin
      z += PI; flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_of_step(i);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_of_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // divide rounding half away from zero
  function automatic longint div_nearest(longint n, longint d);
    longint un, q;
    un = (n < 0) ? -n : n;
    q  = (un + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  // v*cos + u*sin, then scaled back to unit length
  function automatic void rotate_unit(input shortint v[3], input shortint u[3],
                                      input longint c, input longint s,
                                      output shortint o[3]);
    longint w[3];
    longint unsigned len2;
    longint len;
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      w[k] = round_shift(longint'(v[k]) * c + longint'(u[k]) * s, 16);
      len2 += longint'(w[k] * w[k]);
    end
    len = longint'(int_sqrt(len2));
    for (int k = 0; k < 3; k++)
      o[k] = (len == 0) ? 16'sd0 : clamp16(div_nearest(w[k] * (64'sd1 <<< FRAC), len));
  endfunction

  function automatic void cross_prod(input shortint a[3], input shortint b[3],
                                     output shortint o[3]);
    o[0] = clamp16(round_shift(longint'(a[1]) * b[2] - longint'(a[2]) * b[1], FRAC));
    o[1] = clamp16(round_shift(longint'(a[2]) * b[0] - longint'(a[0]) * b[2], FRAC));
    o[2] = clamp16(round_shift(longint'(a[0]) * b[1] - longint'(a[1]) * b[0], FRAC));
  endfunction

  // apply one request to the frame copy and return the new state
  function automatic out_rsp_t apply_request(in_req_t req);
    longint  c, s;
    shortint tmp[3];
    out_rsp_t st;
    if (req.op == OP_MOVE) begin
      for (int k = 0; k < 3; k++)
        pos[k] = clamp32(longint'(pos[k]) +
                         round_shift(longint'(fwd[k]) * longint'(req.speed), FRAC - 8));
    end else begin
      sin_cos(longint'(req.angle) * 131072, c, s);
      case (req.op)
        OP_YAW: begin
          rotate_unit(side, fwd, c, s, tmp); side = tmp;
          cross_prod(up, side, tmp); fwd = tmp;
        end
        OP_ROLL: begin
          rotate_unit(side, up, c, s, tmp); side = tmp;
          cross_prod(side, fwd, tmp); up = tmp;
        end
        default: begin
          rotate_unit(fwd, up, c, s, tmp); fwd = tmp;
          cross_prod(side, fwd, tmp); up = tmp;
        end
      endcase
    end
    st.pos_x = pos[0];  st.pos_y = pos[1];  st.pos_z = pos[2];
    st.fwd_i = fwd[0];  st.fwd_j = fwd[1];  st.fwd_k = fwd[2];
    st.up_i  = up[0];   st.up_j  = up[1];   st.up_k  = up[2];
    st.side_i = side[0]; st.side_j = side[1]; st.side_k = side[2];
    return st;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic compare_field(string nm, longint got, longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", nm, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    if (!rst_ni) begin
      pos  = '{0, 0, 0};
      fwd  = '{0, 0, -16'sd16384};
      up   = '{0, 16'sd16384, 0};
      side = '{16'sd16384, 0, 0};
      expected_states.delete();
    end else begin
      // results first: a result leaving now belongs to an older request
      if (out_valid_i && out_ready_i) begin
        if (expected_states.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_states.pop_front();
          compare_field("pos_x",  out_rsp_i.pos_x,  want.pos_x);
          compare_field("pos_y",  out_rsp_i.pos_y,  want.pos_y);
          compare_field("pos_z",  out_rsp_i.pos_z,  want.pos_z);
          compare_field("fwd_i",  out_rsp_i.fwd_i,  want.fwd_i);
          compare_field("fwd_j",  out_rsp_i.fwd_j,  want.fwd_j);
          compare_field("fwd_k",  out_rsp_i.fwd_k,  want.fwd_k);
          compare_field("up_i",   out_rsp_i.up_i,   want.up_i);
          compare_field("up_j",   out_rsp_i.up_j,   want.up_j);
          compare_field("up_k",   out_rsp_i.up_k,   want.up_k);
          compare_field("side_i", out_rsp_i.side_i, want.side_i);
          compare_field("side_j", out_rsp_i.side_j, want.side_j);
          compare_field("side_k", out_rsp_i.side_k, want.side_k);
        end
      end
      // start register writes load the position at once
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_START_X: pos[0] = cfg_wdata_i;
          CFG_START_Y: pos[1] = cfg_wdata_i;
          CFG_START_Z: pos[2] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_states.push_back(apply_request(in_req_i));
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: body frame attitude update block
// Drives directed and random move, yaw, roll and pitch requests with random
// gaps and result back-pressure, rewrites the start position between phases,
// and lets the checker compare every returned state.
// ----------------------------------------------------------------------------
module testbench import bfa_pkg::*;;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_ready;
  out_rsp_t    out_rsp;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  int          mismatches;
  int          pending;
  int          cycles = 0;
  bit          quiet = 0;

  always #10 clk = ~clk;

  body_frame_attitude_update i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata)
  );

  bfa_state_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_rsp_i(out_rsp),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ready = 1'b1;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // one request, with an optional gap in front of it
  task automatic send_request(op_e op, logic signed [15:0] ang, logic signed [15:0] spd);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{op: op, angle: ang, speed: spd};
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_start(logic [1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_request();
    op_e op;
    logic signed [15:0] ang, spd;
    op = op_e'($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0) ang = 16'($urandom_range(0, 51472) - 25736);
    else ang = 16'($urandom_range(0, 1600) - 800);
    spd = 16'($urandom_range(0, 65535));
    send_request(op, ang, spd);
  endtask

  initial begin
    int lo, hi;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_START_X;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: start near the positive and negative limits so moves saturate
    write_start(CFG_START_X, 32'h7fff_0000);
    write_start(CFG_START_Y, 32'h8000_0000);
    write_start(CFG_START_Z, 32'h7ff0_0000);
    send_request(OP_MOVE, 16'sd0, -16'sd32768);
    send_request(OP_MOVE, 16'sd0, 16'sd32767);
    send_request(OP_MOVE, 16'sd0, -16'sd32768);
    send_request(OP_MOVE, 16'sd0, -16'sd32768);
    send_request(OP_YAW, 16'sd0, 16'sd0);
    send_request(OP_YAW, 16'sd25736, 16'sd0);
    send_request(OP_YAW, -16'sd25736, 16'sd0);
    send_request(OP_ROLL, 16'sd12868, 16'sd0);
    send_request(OP_ROLL, -16'sd12868, 16'sd0);
    send_request(OP_PITCH, 16'sd20000, 16'sd0);
    send_request(OP_PITCH, -16'sd20000, -16'sd1);
    send_request(OP_MOVE, 16'sd0, 16'sd32767);
    send_request(OP_ROLL, 16'sd25735, -16'sd32768);
    send_request(OP_PITCH, 16'sd1, 16'sd32767);
    send_request(OP_MOVE, -16'sd1, -16'sd32768);
    send_request(OP_YAW, -16'sd1, 16'sd0);
    wait_idle();

    // random phases, each starting from a fresh start position
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin lo = 32'h0000_0000; hi = 32'h0000_0000; end
        1: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
        default: begin lo = $urandom; hi = $urandom; end
      endcase
      write_start(CFG_START_X, lo);
      write_start(CFG_START_Y, hi);
      write_start(CFG_START_Z, phase[0] ? lo : hi);
      if (phase == 4) quiet = 1;
      repeat (140) random_request();
      wait_idle();
    end

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
